[rtl/fpes_pkg.sv]
// shared types, codes and constants of the flash program/erase sequencer
package fpes_pkg;

  localparam int BLOCK_BYTES_DEFAULT = 131072;
  localparam int MAX_RESULTS = 5;
  localparam int CNT_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] CMD_READ_ARRAY  = 32'h00FF00FF;
  localparam logic [31:0] CMD_ERASE_SETUP = 32'h00200020;
  localparam logic [31:0] CMD_ERASE_OK    = 32'h00D000D0;
  localparam logic [31:0] CMD_PGM_SETUP   = 32'h00400040;
  localparam logic [31:0] CMD_STATUS_READ = 32'h00700070;
  localparam logic [31:0] ST_READY        = 32'h00800080;
  localparam logic [31:0] ST_ERASE_ERR    = 32'h00200020;
  localparam logic [31:0] ST_PGM_ERR      = 32'h00100010;
  localparam logic [24:0] WORD_MASK       = 25'h0000003;

  localparam logic [1:0] ACT_ERASE = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;
  localparam logic [1:0] ACT_RESP  = 2'd3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_ERASE_ERR = 2'd1;
  localparam logic [1:0] STS_WRITE_ERR = 2'd2;
  localparam logic [1:0] STS_REJECTED  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_REGION0_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION0_MAX  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION0_BLKS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION1_BASE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION1_MAX  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION1_BLKS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ERASE_LOCK   = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ERASE_POLL,
    PH_WAIT_DATA,
    PH_WRITE_POLL,
    PH_VERIFY
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        region;
    logic [23:0] length_bytes;
    logic [31:0] write_word;
    logic [31:0] read_word;
  } in_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic [1:0]  status;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]             count;
    entry_t [MAX_RESULTS-1:0]     ent;
  } batch_t;

  typedef struct packed {
    logic [31:0] region0_base;
    logic [23:0] region0_max_bytes;
    logic [7:0]  region0_blocks;
    logic [31:0] region1_base;
    logic [23:0] region1_max_bytes;
    logic [7:0]  region1_blocks;
    logic        erase_locked;
  } cfg_t;

  function automatic entry_t mk(logic [1:0] op, logic [31:0] addr, logic [31:0] data,
                                logic [1:0] st);
    entry_t e;
    e.op = op;
    e.bus_address = addr;
    e.bus_data = data;
    e.status = st;
    return e;
  endfunction

endpackage

[rtl/fpes_step.sv]
// sequencer state and per-request decision logic producing a batch of bus results
module fpes_step #(
  parameter int BLOCK_BYTES = fpes_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  fpes_pkg::cfg_t  cfg,
  input  logic            take,
  input  fpes_pkg::in_t   item,
  output fpes_pkg::batch_t batch
);

  fpes_pkg::phase_t phase, phase_next;
  logic [31:0] cur_addr, cur_addr_next;
  logic [7:0]  blocks_left, blocks_left_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic [31:0] held_word, held_word_next;

  logic [31:0] sel_base;
  logic [7:0]  sel_blocks;
  logic [23:0] sel_max;
  logic [24:0] len_up;
  logic [23:0] clip_len;
  logic        ready, erase_err, pgm_err, verify_ok, last_block, last_word;
  logic [7:0]  blocks_dec;
  logic [23:0] bytes_dec;
  logic [31:0] next_block_addr;

  assign sel_base   = item.region ? cfg.region1_base : cfg.region0_base;
  assign sel_blocks = item.region ? cfg.region1_blocks : cfg.region0_blocks;
  assign sel_max    = item.region ? cfg.region1_max_bytes : cfg.region0_max_bytes;
  assign len_up     = ({1'b0, item.length_bytes} + fpes_pkg::WORD_MASK) & ~fpes_pkg::WORD_MASK;
  assign clip_len   = (len_up > {1'b0, sel_max}) ? sel_max : len_up[23:0];
  assign ready      = (~item.read_word & fpes_pkg::ST_READY) == 32'd0;
  assign erase_err  = (item.read_word & fpes_pkg::ST_ERASE_ERR) != 32'd0;
  assign pgm_err    = (item.read_word & fpes_pkg::ST_PGM_ERR) != 32'd0;
  assign verify_ok  = item.read_word == held_word;
  assign blocks_dec = blocks_left - 8'd1;
  assign last_block = blocks_dec == 8'd0;
  assign bytes_dec  = (bytes_left > 24'd4) ? bytes_left - 24'd4 : 24'd0;
  assign last_word  = bytes_dec == 24'd0;
  assign next_block_addr = cur_addr + 32'(BLOCK_BYTES);

  always_comb begin
    phase_next = phase;
    case (phase)
      fpes_pkg::PH_IDLE: begin
        if (item.action == fpes_pkg::ACT_ERASE) begin
          if (!cfg.erase_locked && sel_blocks != 8'd0) phase_next = fpes_pkg::PH_ERASE_POLL;
        end else if (item.action == fpes_pkg::ACT_WRITE) begin
          if (clip_len != 24'd0) phase_next = fpes_pkg::PH_WAIT_DATA;
        end
      end
      fpes_pkg::PH_WAIT_DATA: begin
        if (item.action == fpes_pkg::ACT_DATA) phase_next = fpes_pkg::PH_WRITE_POLL;
      end
      fpes_pkg::PH_ERASE_POLL: begin
        if (item.action == fpes_pkg::ACT_RESP && ready && (erase_err || last_block))
          phase_next = fpes_pkg::PH_IDLE;
      end
      fpes_pkg::PH_WRITE_POLL: begin
        if (item.action == fpes_pkg::ACT_RESP && ready)
          phase_next = pgm_err ? fpes_pkg::PH_IDLE : fpes_pkg::PH_VERIFY;
      end
      fpes_pkg::PH_VERIFY: begin
        if (item.action == fpes_pkg::ACT_RESP)
          phase_next = (!verify_ok || last_word) ? fpes_pkg::PH_IDLE : fpes_pkg::PH_WAIT_DATA;
      end
      default: phase_next = fpes_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    batch = '0;
    cur_addr_next = cur_addr;
    blocks_left_next = blocks_left;
    bytes_left_next = bytes_left;
    held_word_next = held_word;
    case (phase)
      fpes_pkg::PH_IDLE: begin
        if (item.action == fpes_pkg::ACT_ERASE) begin
          batch.count = 3'd1;
          if (cfg.erase_locked) begin
            batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_DONE, 32'd0, 32'd0, fpes_pkg::STS_REJECTED);
          end else begin
            cur_addr_next = sel_base;
            blocks_left_next = sel_blocks;
            if (sel_blocks == 8'd0) begin
              batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_DONE, 32'd0, 32'd0, fpes_pkg::STS_OK);
            end else begin
              batch.count = 3'd4;
              batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_WRITE, sel_base,
                                          fpes_pkg::CMD_ERASE_SETUP, fpes_pkg::STS_OK);
              batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_WRITE, sel_base,
                                          fpes_pkg::CMD_ERASE_OK, fpes_pkg::STS_OK);
              batch.ent[2] = fpes_pkg::mk(fpes_pkg::OP_WRITE, sel_base,
                                          fpes_pkg::CMD_STATUS_READ, fpes_pkg::STS_OK);
              batch.ent[3] = fpes_pkg::mk(fpes_pkg::OP_READ, sel_base, 32'd0, fpes_pkg::STS_OK);
            end
          end
        end else if (item.action == fpes_pkg::ACT_WRITE) begin
          cur_addr_next = sel_base;
          bytes_left_next = clip_len;
          if (clip_len == 24'd0) begin
            batch.count = 3'd1;
            batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_DONE, 32'd0, 32'd0, fpes_pkg::STS_OK);
          end
        end
      end
      fpes_pkg::PH_WAIT_DATA: begin
        if (item.action == fpes_pkg::ACT_DATA) begin
          held_word_next = item.write_word;
          batch.count = 3'd4;
          batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_WRITE, cur_addr,
                                      fpes_pkg::CMD_PGM_SETUP, fpes_pkg::STS_OK);
          batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_WRITE, cur_addr,
                                      item.write_word, fpes_pkg::STS_OK);
          batch.ent[2] = fpes_pkg::mk(fpes_pkg::OP_WRITE, cur_addr,
                                      fpes_pkg::CMD_STATUS_READ, fpes_pkg::STS_OK);
          batch.ent[3] = fpes_pkg::mk(fpes_pkg::OP_READ, cur_addr, 32'd0, fpes_pkg::STS_OK);
        end
      end
      fpes_pkg::PH_ERASE_POLL, fpes_pkg::PH_WRITE_POLL: begin
        if (item.action == fpes_pkg::ACT_RESP) begin
          if (!ready) begin
            batch.count = 3'd2;
            batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_WRITE, cur_addr,
                                        fpes_pkg::CMD_STATUS_READ, fpes_pkg::STS_OK);
            batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_READ, cur_addr, 32'd0, fpes_pkg::STS_OK);
          end else begin
            batch.count = 3'd2;
            batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_WRITE, cur_addr,
                                        fpes_pkg::CMD_READ_ARRAY, fpes_pkg::STS_OK);
            if (phase == fpes_pkg::PH_WRITE_POLL) begin
              if (pgm_err)
                batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_DONE, cur_addr, 32'd0,
                                            fpes_pkg::STS_WRITE_ERR);
              else
                batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_READ, cur_addr, 32'd0,
                                            fpes_pkg::STS_OK);
            end else if (erase_err) begin
              batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_DONE, cur_addr, 32'd0,
                                          fpes_pkg::STS_ERASE_ERR);
            end else begin
              blocks_left_next = blocks_dec;
              cur_addr_next = next_block_addr;
              if (last_block) begin
                batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_DONE, 32'd0, 32'd0, fpes_pkg::STS_OK);
              end else begin
                batch.count = 3'd5;
                batch.ent[1] = fpes_pkg::mk(fpes_pkg::OP_WRITE, next_block_addr,
                                            fpes_pkg::CMD_ERASE_SETUP, fpes_pkg::STS_OK);
                batch.ent[2] = fpes_pkg::mk(fpes_pkg::OP_WRITE, next_block_addr,
                                            fpes_pkg::CMD_ERASE_OK, fpes_pkg::STS_OK);
                batch.ent[3] = fpes_pkg::mk(fpes_pkg::OP_WRITE, next_block_addr,
                                            fpes_pkg::CMD_STATUS_READ, fpes_pkg::STS_OK);
                batch.ent[4] = fpes_pkg::mk(fpes_pkg::OP_READ, next_block_addr, 32'd0,
                                            fpes_pkg::STS_OK);
              end
            end
          end
        end
      end
      fpes_pkg::PH_VERIFY: begin
        if (item.action == fpes_pkg::ACT_RESP) begin
          if (!verify_ok) begin
            batch.count = 3'd1;
            batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_DONE, cur_addr, 32'd0,
                                        fpes_pkg::STS_WRITE_ERR);
          end else begin
            bytes_left_next = bytes_dec;
            cur_addr_next = cur_addr + 32'd4;
            if (last_word) begin
              batch.count = 3'd1;
              batch.ent[0] = fpes_pkg::mk(fpes_pkg::OP_DONE, 32'd0, 32'd0, fpes_pkg::STS_OK);
            end
          end
        end
      end
      default: batch = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fpes_pkg::PH_IDLE;
      cur_addr <= '0;
      blocks_left <= '0;
      bytes_left <= '0;
      held_word <= '0;
    end else if (take) begin
      phase <= phase_next;
      cur_addr <= cur_addr_next;
      blocks_left <= blocks_left_next;
      bytes_left <= bytes_left_next;
      held_word <= held_word_next;
    end
  end

endmodule

[rtl/fpes_out.sv]
// result register: holds one batch and shifts its entries out one per cycle while out_stall is low
module fpes_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fpes_pkg::batch_t batch,
  input  logic             out_stall,
  output logic             out_valid,
  output fpes_pkg::out_t   out_data,
  output logic             free
);

  fpes_pkg::entry_t [fpes_pkg::MAX_RESULTS-1:0] ent;
  logic [fpes_pkg::CNT_W-1:0] rem;
  logic pop;

  assign out_valid = rem != '0;
  assign pop = out_valid && !out_stall;
  assign free = !out_valid || (pop && rem == fpes_pkg::CNT_W'(1));

  assign out_data.op = ent[0].op;
  assign out_data.bus_address = ent[0].bus_address;
  assign out_data.bus_data = ent[0].bus_data;
  assign out_data.status = ent[0].status;
  assign out_data.last = rem == fpes_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= batch.count;
    end else if (pop) begin
      rem <= rem - fpes_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= batch.ent;
    end else if (pop) begin
      for (int i = 0; i < fpes_pkg::MAX_RESULTS - 1; i++) ent[i] <= ent[i + 1];
    end
  end

endmodule

[rtl/flash_program_erase_sequencer_core.sv]
// top level of the flash program/erase sequencer: config registers, step logic, result buffer
//
// channel  dir  payload           handshake
// in       in   in_data (in_t)    in_valid / in_stall
// out      out  out_data (out_t)  out_valid / out_stall
// cfg      in   cfg_index, data   cfg_we
//
// a request yields zero to five results, one per cycle while out_stall is low
// the next request is taken in the cycle the last result of the previous one is taken
// sustained rate is set by the result shift buffer, which holds five results at most
// rst is synchronous and clears phase, counters, config and the result buffer
// out_stall holds the current result; in_stall rises while earlier results remain, unless the last is taken
module flash_program_erase_sequencer_core #(
  parameter int BLOCK_BYTES = fpes_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fpes_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fpes_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [fpes_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fpes_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fpes_pkg::cfg_t   cfg;
  fpes_pkg::batch_t batch;
  logic free;
  logic take;

  assign in_stall = !free;
  assign take = in_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fpes_pkg::REG_REGION0_BASE: cfg.region0_base <= cfg_data;
        fpes_pkg::REG_REGION0_MAX:  cfg.region0_max_bytes <= cfg_data[23:0];
        fpes_pkg::REG_REGION0_BLKS: cfg.region0_blocks <= cfg_data[7:0];
        fpes_pkg::REG_REGION1_BASE: cfg.region1_base <= cfg_data;
        fpes_pkg::REG_REGION1_MAX:  cfg.region1_max_bytes <= cfg_data[23:0];
        fpes_pkg::REG_REGION1_BLKS: cfg.region1_blocks <= cfg_data[7:0];
        fpes_pkg::REG_ERASE_LOCK:   cfg.erase_locked <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  fpes_step #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .take  (take),
    .item  (in_data),
    .batch (batch)
  );

  fpes_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .batch     (batch),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (free)
  );

  a_take_when_drained: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid || (!out_stall && out_data.last))
    else $error("request taken while results still pending");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.op == fpes_pkg::OP_DONE |-> out_data.last)
    else $error("finished result not last of its batch");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.op != fpes_pkg::OP_DONE |-> out_data.status == fpes_pkg::STS_OK)
    else $error("status set on a bus access");

  a_read_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.op == fpes_pkg::OP_READ |-> out_data.bus_data == 32'd0)
    else $error("read request carries data");

endmodule
